// ===== hdl/gdrc_pkg.sv =====
package gdrc_pkg;

	localparam int MAP_COLS = 32;
	localparam int MAP_ROWS = 32;
	localparam int FRAC_BITS = 10;

	localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;
	localparam int ADDR_W = $clog2(MAP_CELLS);
	localparam int COL_W = $clog2(MAP_COLS);
	localparam int ROW_W = $clog2(MAP_ROWS);

	localparam int POS_W = 15;
	localparam int DIST_W = 15;
	localparam int IDX_W = 5;
	localparam int ANG_W = 9;

	localparam int DEG_QUARTER = 90;
	localparam int DEG_HALF = 180;
	localparam int DEG_FULL = 360;
	localparam int DEG_W = $clog2(DEG_QUARTER + 1);

	localparam int RECIP_W = FRAC_BITS + 8;
	localparam int LEN_W = RECIP_W + 2;
	localparam int FRAC1_W = FRAC_BITS + 1;
	localparam int MUL_W = FRAC1_W + RECIP_W;
	localparam int PX_W = POS_W + 1;
	localparam int CELL_W = PX_W - FRAC_BITS;
	localparam int MAP_SPAN = (MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS;
	localparam int MAP_IDX_W = $clog2(MAP_SPAN + 1);
	localparam int COORD_W = ((CELL_W > MAP_IDX_W) ? CELL_W : MAP_IDX_W) + 3;

	localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = DIST_W'(15360);
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] RECIP_MAX = (64'd1 << RECIP_W) - 64'd1;
	localparam int RECIP_TOP = 30 + FRAC_BITS;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST = 1'b1;

	typedef logic [RECIP_W-1:0] step_rom_t [0:DEG_QUARTER];

	function automatic logic [RECIP_W-1:0] step_len_f(input int unsigned d);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] s;
		logic [63:0] rem;
		logic [63:0] q;
		int i;
		x = 64'(d) * PI_Q30 / 64'd180;
		x2 = (x * x) >> 30;
		sum = x;
		term = ((x * x2) >> 30) / 64'd6;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum = (sum >= term) ? sum - term : 64'd0;
		s = (sum > ONE_Q30) ? ONE_Q30 : sum;
		if (s == 64'd0) begin
			return RECIP_W'(RECIP_MAX);
		end
		rem = 64'd0;
		q = 64'd0;
		for (i = RECIP_TOP; i >= 0; i--) begin
			rem = {rem[62:0], (i == RECIP_TOP)};
			if (rem >= s) begin
				rem = rem - s;
				q[i] = 1'b1;
			end
		end
		return (q > RECIP_MAX) ? RECIP_W'(RECIP_MAX) : RECIP_W'(q);
	endfunction

	function automatic step_rom_t build_step_rom();
		step_rom_t rom;
		for (int d = 0; d <= DEG_QUARTER; d++) begin
			rom[d] = step_len_f(d);
		end
		return rom;
	endfunction

	localparam step_rom_t STEP_ROM = build_step_rom();

endpackage

// ===== hdl/grid_dda_ray_cast.sv =====
// Grid ray caster over a one-bit wall map, walked cell edge to cell edge.
// Command channel (cmd_valid, cmd_stall): operation 0 writes wall_bit into the
// map cell (cell_col, cell_row) with no result; operation 1 casts a ray from
// (start_x, start_y) at angle_deg and returns one result item.
// Result channel (res_valid, res_stall): hit_distance, hit_found, hit_col and
// hit_row, held in an output register until the receiver takes them.
// A cast walks the cell edges it crosses; each step does the edge compare and
// add in ST_STEP and checks the registered map read in ST_CHECK. With the
// reset cap of 15 cells a cast crosses under about 25 cell edges. The block
// takes one item at a time and stalls the command channel while a cast is in
// flight.
// A finished result waits in the output register while the receiver stalls, and
// the next command is accepted meanwhile; a later cast waits at its end until
// the register is free.
// After reset the block clears the 1024-cell map, one cell a cycle, stalling
// cmd_stall until done. max_distance resets to 15 cells; the user must write it
// through cfg_wr_en and cfg_wr_data only while idle, which is not checked.
module grid_dda_ray_cast (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gdrc_pkg::DIST_W-1:0] cfg_wr_data,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic                        operation,
	input  logic [gdrc_pkg::IDX_W-1:0]  cell_col,
	input  logic [gdrc_pkg::IDX_W-1:0]  cell_row,
	input  logic                        wall_bit,
	input  logic [gdrc_pkg::POS_W-1:0]  start_x,
	input  logic [gdrc_pkg::POS_W-1:0]  start_y,
	input  logic [gdrc_pkg::ANG_W-1:0]  angle_deg,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [gdrc_pkg::DIST_W-1:0] hit_distance,
	output logic                        hit_found,
	output logic [gdrc_pkg::IDX_W-1:0]  hit_col,
	output logic [gdrc_pkg::IDX_W-1:0]  hit_row
);
	import gdrc_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_PREP   = 8'b0000_0100,
		ST_MULX   = 8'b0000_1000,
		ST_MULY   = 8'b0001_0000,
		ST_STEP   = 8'b0010_0000,
		ST_CHECK  = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	logic [DIST_W-1:0] max_q;
	logic [ADDR_W-1:0] clr_q;
	logic              res_valid_q;

	logic              mem [0:MAP_CELLS-1];
	logic              rd_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;
	logic [ADDR_W-1:0] rd_addr;

	logic                        cmd_accept;
	logic                        wr_in_map;
	logic [ANG_W-1:0]            ang_in;
	logic [PX_W-1:0]             px_in, py_in;

	logic [ANG_W-1:0]            ang_q;
	logic signed [COORD_W-1:0]   mx_q, my_q;
	logic [FRAC_BITS-1:0]        fracx_q, fracy_q;
	logic                        negx_q, negy_q;
	logic [RECIP_W-1:0]          ux_q, uy_q;
	logic [LEN_W-1:0]            lenx_q, leny_q, t_q;
	logic                        inmap_q;
	logic                        hit_q;

	logic [ANG_W-1:0]            ang_r;
	logic [DEG_W-1:0]            cdeg, sdeg;

	logic [FRAC1_W-1:0]          mul_a;
	logic [RECIP_W-1:0]          mul_b;
	logic [MUL_W-1:0]            mul_p;
	logic [LEN_W-1:0]            mul_len;

	logic                        step_x;
	logic signed [COORD_W-1:0]   mx_nx, my_nx;
	logic                        inmap_nx;
	logic                        hit_now;
	logic                        walk_done;
	logic                        res_load;

	logic [DIST_W-1:0]           dist_out;
	logic                        found_out;

	logic [DIST_W-1:0]           hit_distance_q;
	logic                        hit_found_q;
	logic [IDX_W-1:0]            hit_col_q, hit_row_q;

	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;

	assign wr_in_map = (32'(cell_col) < MAP_COLS) && (32'(cell_row) < MAP_ROWS);

	assign ang_in = (angle_deg >= ANG_W'(DEG_FULL)) ? angle_deg - ANG_W'(DEG_FULL) : angle_deg;
	assign px_in  = PX_W'(start_x) + PX_W'(1 << (FRAC_BITS - 1));
	assign py_in  = PX_W'(start_y) + PX_W'(1 << (FRAC_BITS - 1));

	always_comb begin
		ang_r = (ang_q >= ANG_W'(DEG_HALF)) ? ang_q - ANG_W'(DEG_HALF) : ang_q;
		if (ang_r <= ANG_W'(DEG_QUARTER)) begin
			cdeg = DEG_W'(ANG_W'(DEG_QUARTER) - ang_r);
			sdeg = DEG_W'(ang_r);
		end else begin
			cdeg = DEG_W'(ang_r - ANG_W'(DEG_QUARTER));
			sdeg = DEG_W'(ANG_W'(DEG_HALF) - ang_r);
		end
	end

	always_comb begin
		if (state_q == ST_MULX) begin
			mul_a = negx_q ? FRAC1_W'(fracx_q) : FRAC1_W'(1 << FRAC_BITS) - FRAC1_W'(fracx_q);
			mul_b = ux_q;
		end else begin
			mul_a = negy_q ? FRAC1_W'(fracy_q) : FRAC1_W'(1 << FRAC_BITS) - FRAC1_W'(fracy_q);
			mul_b = uy_q;
		end
		mul_p   = MUL_W'(mul_a) * MUL_W'(mul_b);
		mul_len = LEN_W'(mul_p >> FRAC_BITS);
	end

	always_comb begin
		step_x = (lenx_q < leny_q);
		mx_nx  = mx_q;
		my_nx  = my_q;
		if (step_x) begin
			mx_nx = negx_q ? mx_q - COORD_W'(1) : mx_q + COORD_W'(1);
		end else begin
			my_nx = negy_q ? my_q - COORD_W'(1) : my_q + COORD_W'(1);
		end
		inmap_nx = !mx_nx[COORD_W-1] && !my_nx[COORD_W-1]
			&& (mx_nx < $signed(COORD_W'(MAP_COLS)))
			&& (my_nx < $signed(COORD_W'(MAP_ROWS)));
		rd_addr = ADDR_W'(my_nx[ROW_W-1:0]) * ADDR_W'(MAP_COLS) + ADDR_W'(mx_nx[COL_W-1:0]);
	end

	assign hit_now   = inmap_q && rd_q;
	assign walk_done = hit_now || (t_q > LEN_W'(max_q));
	assign res_load  = (state_q == ST_FINISH) && (!res_valid_q || !res_stall);

	assign found_out = hit_q && (t_q <= LEN_W'(max_q));
	assign dist_out  = (t_q < LEN_W'(max_q)) ? DIST_W'(t_q) : max_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 1'b0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (cmd_accept && (operation == OP_WRITE) && wr_in_map) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(cell_row) * ADDR_W'(MAP_COLS) + ADDR_W'(cell_col);
			mem_wdata = wall_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_STEP) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(MAP_CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_accept && (operation == OP_CAST)) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP:   state_d = ST_MULX;
			ST_MULX:   state_d = ST_MULY;
			ST_MULY:   state_d = ST_STEP;
			ST_STEP:   state_d = ST_CHECK;
			ST_CHECK:  state_d = walk_done ? ST_FINISH : ST_STEP;
			ST_FINISH: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			max_q       <= MAX_DISTANCE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ang_q   <= ang_in;
				mx_q    <= $signed(COORD_W'(px_in[PX_W-1:FRAC_BITS]));
				my_q    <= $signed(COORD_W'(py_in[PX_W-1:FRAC_BITS]));
				fracx_q <= px_in[FRAC_BITS-1:0];
				fracy_q <= py_in[FRAC_BITS-1:0];
				t_q     <= '0;
				hit_q   <= 1'b0;
			end
			ST_PREP: begin
				negx_q <= (ang_q > ANG_W'(DEG_QUARTER)) && (ang_q < ANG_W'(DEG_FULL - DEG_QUARTER));
				negy_q <= (ang_q != '0) && (ang_q < ANG_W'(DEG_HALF));
				ux_q   <= STEP_ROM[cdeg];
				uy_q   <= STEP_ROM[sdeg];
			end
			ST_MULX: begin
				lenx_q <= mul_len;
			end
			ST_MULY: begin
				leny_q <= mul_len;
			end
			ST_STEP: begin
				mx_q    <= mx_nx;
				my_q    <= my_nx;
				inmap_q <= inmap_nx;
				if (step_x) begin
					t_q    <= lenx_q;
					lenx_q <= lenx_q + LEN_W'(ux_q);
				end else begin
					t_q    <= leny_q;
					leny_q <= leny_q + LEN_W'(uy_q);
				end
			end
			ST_CHECK: begin
				hit_q <= hit_now;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			hit_distance_q <= dist_out;
			hit_found_q    <= found_out;
			hit_col_q      <= found_out ? IDX_W'(mx_q[COL_W-1:0]) : '0;
			hit_row_q      <= found_out ? IDX_W'(my_q[ROW_W-1:0]) : '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign hit_distance = hit_distance_q;
	assign hit_found    = hit_found_q;
	assign hit_col      = hit_col_q;
	assign hit_row      = hit_row_q;

endmodule
